>>> hw/rtl/remaining_time_median_estimator_defines.svh
// Assertion macros for the remaining-time median estimator.
// Included by the top level only; depends on nothing else.
`ifndef REMAINING_TIME_MEDIAN_ESTIMATOR_DEFINES_SVH
`define REMAINING_TIME_MEDIAN_ESTIMATOR_DEFINES_SVH

// Checks a consequence in the same cycle as its cause.
`define RTME_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a consequence in the cycle after its cause.
`define RTME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rtme_pkg.sv
// Shared types and constants of the remaining-time median estimator.
// Used by the divider, the sort cell and the top level; depends on nothing.
package rtme_pkg;

    // Field widths.
    localparam int SPEED_W = 40;
    localparam int BYTES_W = 48;
    localparam int EST_W   = 63;

    // Serial divider: one quotient bit per cycle.
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(BYTES_W - 1);

    // Estimate used for a stalled transfer.
    localparam logic [EST_W-1:0] EST_INFINITE = {EST_W{1'b1}};

    // Item modes.
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_SEED   = 2'd2;

    // Input item.
    typedef struct packed {
        logic [1:0]         mode;
        logic [SPEED_W-1:0] speed;
        logic [BYTES_W-1:0] remaining_bytes;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [EST_W-1:0] remaining_seconds;
        logic             median_updated;
    } t_out_item;

    // Value handed from one sort cell to the next.
    typedef struct packed {
        logic             vld;
        logic [EST_W-1:0] data;
    } t_pass;

endpackage

>>> hw/rtl/rtme_div.sv
// Restoring serial divider: remaining bytes over speed, one quotient bit per cycle.
// Depends on rtme_pkg for widths.
module rtme_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rtme_pkg::BYTES_W-1:0] i_dividend,
    input  logic [rtme_pkg::SPEED_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [rtme_pkg::BYTES_W-1:0] o_quotient
);

    logic                           r_busy;
    logic                           r_done;
    logic [rtme_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [rtme_pkg::SPEED_W-1:0]   r_rem;
    logic [rtme_pkg::SPEED_W-1:0]   r_dsr;
    logic [rtme_pkg::BYTES_W-1:0]   r_quo;

    logic [rtme_pkg::SPEED_W:0]     trial;
    logic [rtme_pkg::SPEED_W:0]     diff;
    logic                           fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        trial = {r_rem, r_quo[rtme_pkg::BYTES_W-1]};
        diff  = trial - {1'b0, r_dsr};
        fits  = (trial >= {1'b0, r_dsr});
    end

    // Control: run for one step per dividend bit, then pulse done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == rtme_pkg::DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? diff[rtme_pkg::SPEED_W-1:0] : trial[rtme_pkg::SPEED_W-1:0];
            r_quo <= {r_quo[rtme_pkg::BYTES_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> hw/rtl/rtme_sort_cell.sv
// One cell of the insertion sorter: keeps the smallest value it has seen
// and hands every other one to its neighbor. Depends on rtme_pkg.
module rtme_sort_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clear,
    input  rtme_pkg::t_pass           i_pass,
    output rtme_pkg::t_pass           o_pass,
    output logic [rtme_pkg::EST_W-1:0] o_val,
    output logic                      o_full
);

    logic                       r_full;
    logic                       r_pass_vld;
    logic [rtme_pkg::EST_W-1:0] r_val;
    logic [rtme_pkg::EST_W-1:0] r_pass_data;

    logic                       keep_new;

    // A new value replaces the held one when the cell is empty or it is smaller.
    assign keep_new = !r_full || (i_pass.data < r_val);

    // Control: occupancy and the valid of the outgoing transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_full     <= 1'b0;
            r_pass_vld <= 1'b0;
        end else begin
            r_pass_vld <= i_pass.vld && r_full;
            if (i_pass.vld) begin
                r_full <= 1'b1;
            end
        end
    end

    // Datapath: hold the minimum, pass the other value on.
    always_ff @(posedge i_clk) begin
        if (i_pass.vld) begin
            if (keep_new) begin
                r_val       <= i_pass.data;
                r_pass_data <= r_val;
            end else begin
                r_pass_data <= i_pass.data;
            end
        end
    end

    assign o_pass.vld  = r_pass_vld;
    assign o_pass.data = r_pass_data;
    assign o_val       = r_val;
    assign o_full      = r_full;

endmodule

>>> hw/rtl/remaining_time_median_estimator.sv
// Remaining-time median estimator. Each transfer carries a speed and a remaining
// byte count; the block divides them into a seconds estimate (all ones when the
// speed is zero), pushes it into a ring of RING_DEPTH estimates, and on every
// completed ring pass replaces the held estimate with the ring's median (the
// upper middle element for an even depth). Every input item yields one result
// carrying the held estimate and an updated flag. Steps: clear, a seed at zero
// speed and the unused mode go straight to the result; any other sample or seed
// first runs the serial divider (48 steps, one quotient bit a cycle); a sample
// that completes a ring pass then rotates the ring once through the chain of
// sort cells and lets the last value settle. A new item is taken as soon as
// the previous result sits in the output register.
// Depends on rtme_pkg, rtme_div, rtme_sort_cell and the assertion macro header.
`include "remaining_time_median_estimator_defines.svh"

module remaining_time_median_estimator #(
    parameter int RING_DEPTH = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rtme_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rtme_pkg::t_out_item o_data
);

    localparam int PW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SCW = $clog2(2 * RING_DEPTH);
    localparam int MID = RING_DEPTH / 2;
    localparam logic [PW-1:0]  POS_LAST  = PW'(RING_DEPTH - 1);
    localparam logic [SCW-1:0] SCNT_FEED = SCW'(RING_DEPTH);
    localparam logic [SCW-1:0] SCNT_LAST = SCW'(2 * RING_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SORT = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // Control registers.
    logic [1:0]                 r_state,   n_state;
    logic [1:0]                 r_mode,    n_mode;
    logic                       r_spd_zero, n_spd_zero;
    logic [PW-1:0]              r_pos,     n_pos;
    logic [SCW-1:0]             r_scnt,    n_scnt;
    logic                       r_out_vld, n_out_vld;

    // State and payload registers.
    logic [rtme_pkg::EST_W-1:0] r_held, n_held;
    logic [rtme_pkg::EST_W-1:0] r_ring [RING_DEPTH];
    logic [rtme_pkg::EST_W-1:0] n_ring [RING_DEPTH];
    rtme_pkg::t_out_item        r_res, n_res;
    rtme_pkg::t_out_item        r_out, n_out;

    logic                         accept;
    logic                         div_start;
    logic                         div_done;
    logic [rtme_pkg::BYTES_W-1:0] div_quo;
    logic [rtme_pkg::EST_W-1:0]   est;
    logic                         sort_clr;
    logic                         feed_vld;
    rtme_pkg::t_pass              chain [RING_DEPTH + 1];
    logic [rtme_pkg::EST_W-1:0]   cell_val [RING_DEPTH];
    logic [RING_DEPTH-1:0]        cell_full;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    // Serial divider for the seconds estimate.
    rtme_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_data.remaining_bytes),
        .i_divisor  (i_data.speed),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign est = r_spd_zero ? rtme_pkg::EST_INFINITE : rtme_pkg::EST_W'(div_quo);

    // Chain of sort cells; the ring is fed in at the head, one value a cycle.
    assign chain[0].vld  = feed_vld;
    assign chain[0].data = r_ring[RING_DEPTH-1];

    for (genvar g = 0; g < RING_DEPTH; g++) begin : g_cell
        rtme_sort_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (sort_clr),
            .i_pass  (chain[g]),
            .o_pass  (chain[g+1]),
            .o_val   (cell_val[g]),
            .o_full  (cell_full[g])
        );
    end

    // Sequencer: clear, or divide and update or seed the ring, sort on a completed pass, then deliver.
    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_spd_zero = r_spd_zero;
        n_pos      = r_pos;
        n_scnt     = r_scnt;
        n_held     = r_held;
        n_res      = r_res;
        n_out      = r_out;
        n_out_vld  = r_out_vld;
        n_ring     = r_ring;
        div_start  = 1'b0;
        sort_clr   = 1'b0;
        feed_vld   = 1'b0;

        // A waiting result leaves when the consumer takes the transfer.
        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_mode     = i_data.mode;
                    n_spd_zero = (i_data.speed == '0);
                    case (i_data.mode)
                        rtme_pkg::MODE_SAMPLE: begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end
                        rtme_pkg::MODE_CLEAR: begin
                            for (int k = 0; k < RING_DEPTH; k++) begin
                                n_ring[k] = '0;
                            end
                            n_pos   = '0;
                            n_held  = '0;
                            n_res.remaining_seconds = '0;
                            n_res.median_updated    = 1'b0;
                            n_state = ST_FIN;
                        end
                        rtme_pkg::MODE_SEED: begin
                            if (i_data.speed == '0) begin
                                // A stalled seed clears everything.
                                for (int k = 0; k < RING_DEPTH; k++) begin
                                    n_ring[k] = '0;
                                end
                                n_pos   = '0;
                                n_held  = '0;
                                n_res.remaining_seconds = '0;
                                n_res.median_updated    = 1'b0;
                                n_state = ST_FIN;
                            end else begin
                                div_start = 1'b1;
                                n_state   = ST_DIV;
                            end
                        end
                        default: begin
                            // The unused mode leaves the state alone.
                            n_res.remaining_seconds = r_held;
                            n_res.median_updated    = 1'b0;
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (r_mode == rtme_pkg::MODE_SEED) begin
                        for (int k = 0; k < RING_DEPTH; k++) begin
                            n_ring[k] = est;
                        end
                        n_pos   = '0;
                        n_held  = est;
                        n_res.remaining_seconds = est;
                        n_res.median_updated    = 1'b1;
                        n_state = ST_FIN;
                    end else begin
                        // The ring is a shift line: only its contents matter
                        // for the median, and the oldest estimate drops out.
                        n_ring[0] = est;
                        for (int k = 1; k < RING_DEPTH; k++) begin
                            n_ring[k] = r_ring[k-1];
                        end
                        if (r_pos == POS_LAST) begin
                            n_pos    = '0;
                            n_scnt   = '0;
                            sort_clr = 1'b1;
                            n_state  = ST_SORT;
                        end else begin
                            n_pos   = r_pos + 1'b1;
                            n_res.remaining_seconds = r_held;
                            n_res.median_updated    = 1'b0;
                            n_state = ST_FIN;
                        end
                    end
                end
            end
            ST_SORT: begin
                // Rotate the ring once through the sorter, then let it settle.
                feed_vld = (r_scnt < SCNT_FEED);
                if (feed_vld) begin
                    n_ring[0] = r_ring[RING_DEPTH-1];
                    for (int k = 1; k < RING_DEPTH; k++) begin
                        n_ring[k] = r_ring[k-1];
                    end
                end
                if (r_scnt == SCNT_LAST) begin
                    n_held  = cell_val[MID];
                    n_res.remaining_seconds = cell_val[MID];
                    n_res.median_updated    = 1'b1;
                    n_state = ST_FIN;
                end else begin
                    n_scnt = r_scnt + 1'b1;
                end
            end
            ST_FIN: begin
                if (!r_out_vld || i_ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mode     <= rtme_pkg::MODE_SAMPLE;
            r_spd_zero <= 1'b0;
            r_pos      <= '0;
            r_scnt     <= '0;
            r_out_vld  <= 1'b0;
            r_held     <= '0;
            for (int k = 0; k < RING_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_spd_zero <= n_spd_zero;
            r_pos      <= n_pos;
            r_scnt     <= n_scnt;
            r_out_vld  <= n_out_vld;
            r_held     <= n_held;
            r_ring     <= n_ring;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Checks on the sequencer and the sort chain.
    `RTME_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != ST_IDLE, "accepted item did not start work")
    `RTME_ASSERT_SAME(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == ST_DIV, "divider finished outside the divide step")
    `RTME_ASSERT_SAME(a_sort_pos_zero, i_clk, i_rst_n, r_state == ST_SORT, r_pos == '0, "sorting while the ring position is not at its start")
    `RTME_ASSERT_SAME(a_cells_full, i_clk, i_rst_n, (r_state == ST_SORT) && (r_scnt == SCNT_LAST), &cell_full, "median read before every sort cell holds a value")
    `RTME_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, 1'b1, !chain[RING_DEPTH].vld, "a value fell off the end of the sort chain")

endmodule

>>> bench/tb.sv
// Testbench for the remaining-time median estimator: a directed table, then random
// transfers with random idling, each result checked against a typed row or predictor.
// Depends on rtme_pkg and the remaining_time_median_estimator top level.
module tb;
    import rtme_pkg::*;

    localparam int RING_DEPTH    = 5;
    localparam int RANDOM_ITEMS  = 900;
    localparam int CALM_TAIL     = 100;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 2 * RING_DEPTH + 64;

    // The fourth mode has no meaning and must leave the state alone.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    // One row of the directed table.
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    // Expectation typed into the table, travelling with the item being offered.
    bit        pin_typed;
    t_out_item pin_exp;

    // Predictor state: estimate ring, write slot and held median.
    logic [EST_W-1:0] ring_est [RING_DEPTH];
    int unsigned      ring_wpos;
    logic [EST_W-1:0] held_est;

    t_out_item pending_q[$];

    bit calm;
    int gap_pct;
    int fail_count;
    int stalled_cycles;
    int items_taken;
    int results_seen;
    int updates_seen;
    int clears_taken;
    int seeds_taken;
    logic [SPEED_W-1:0] prev_speed;
    logic [BYTES_W-1:0] prev_bytes;

    remaining_time_median_estimator #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Whole seconds left at the given speed; a stalled transfer never ends.
    function automatic logic [EST_W-1:0] seconds_left(logic [SPEED_W-1:0] speed,
                                                      logic [BYTES_W-1:0] bytes);
        if (speed == '0) begin
            return EST_INFINITE;
        end
        return EST_W'(bytes / speed);
    endfunction

    // Middle of the sorted ring; for an even depth the upper of the two.
    function automatic logic [EST_W-1:0] ring_middle();
        logic [EST_W-1:0] srt [RING_DEPTH];
        logic [EST_W-1:0] v;
        int j;
        srt = ring_est;
        for (int i = 1; i < RING_DEPTH; i++) begin
            v = srt[i];
            j = i;
            while (j > 0 && srt[j-1] > v) begin
                srt[j] = srt[j-1];
                j--;
            end
            srt[j] = v;
        end
        return srt[RING_DEPTH/2];
    endfunction

    task automatic wipe_estimator();
        for (int k = 0; k < RING_DEPTH; k++) begin
            ring_est[k] = '0;
        end
        ring_wpos = 0;
        held_est  = '0;
    endtask

    // Advances the predictor by one item and returns the result it must produce.
    task automatic step_estimator(input t_in_item it, output t_out_item res);
        logic             upd;
        logic [EST_W-1:0] e;
        upd = 1'b0;
        case (it.mode)
            MODE_SAMPLE: begin
                ring_est[ring_wpos] = seconds_left(it.speed, it.remaining_bytes);
                ring_wpos = (ring_wpos + 1) % RING_DEPTH;
                if (ring_wpos == 0) begin
                    held_est = ring_middle();
                    upd      = 1'b1;
                end
            end
            MODE_CLEAR: begin
                wipe_estimator();
            end
            MODE_SEED: begin
                if (it.speed == '0) begin
                    wipe_estimator();
                end else begin
                    e = seconds_left(it.speed, it.remaining_bytes);
                    for (int k = 0; k < RING_DEPTH; k++) begin
                        ring_est[k] = e;
                    end
                    ring_wpos = 0;
                    held_est  = e;
                    upd       = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res.remaining_seconds = held_est;
        res.median_updated    = upd;
    endtask

    function automatic t_row mk_row(logic [1:0] m, logic [SPEED_W-1:0] s,
                                    logic [BYTES_W-1:0] b, bit typed,
                                    logic [EST_W-1:0] sec, logic upd);
        t_row r;
        r.item.mode            = m;
        r.item.speed           = s;
        r.item.remaining_bytes = b;
        r.typed                = typed;
        r.want.remaining_seconds = sec;
        r.want.median_updated    = upd;
        return r;
    endfunction

    // Mostly samples, so that ring passes complete often; magnitudes spread
    // by random shifts, and repeated pairs to force equal estimates.
    function automatic t_in_item random_item();
        t_in_item    it;
        int          sel;
        logic [63:0] r;
        sel = $urandom_range(99);
        if (sel < 84) begin
            it.mode = MODE_SAMPLE;
        end else if (sel < 90) begin
            it.mode = MODE_SEED;
        end else if (sel < 95) begin
            it.mode = MODE_CLEAR;
        end else begin
            it.mode = MODE_UNUSED;
        end
        r = {$urandom(), $urandom()};
        it.speed = r[SPEED_W-1:0] >> $urandom_range(0, SPEED_W - 1);
        r = {$urandom(), $urandom()};
        it.remaining_bytes = r[BYTES_W-1:0] >> $urandom_range(0, BYTES_W - 1);
        if ($urandom_range(19) == 0) begin
            it.speed = '0;
        end
        if ($urandom_range(9) == 0) begin
            it.speed           = prev_speed;
            it.remaining_bytes = prev_bytes;
        end
        prev_speed = it.speed;
        prev_bytes = it.remaining_bytes;
        return it;
    endfunction

    // Offers one item, after an optional idle burst, and holds it until the transfer.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        int gap;
        if (!calm && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_data    <= it;
        pin_typed <= typed;
        pin_exp   <= want;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Result side: ready drops in random bursts, never in the calm tail.
    initial begin
        int hold;
        int pct;
        int cyc;
        hold = 0;
        pct  = 0;
        cyc  = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 300 == 0) begin
                case ($urandom_range(2))
                    0:       pct = 0;
                    1:       pct = 10;
                    default: pct = 35;
                endcase
            end
            if (calm) begin
                i_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else if ($urandom_range(99) < pct) begin
                hold = $urandom_range(1, 12) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Predicts on every input transfer and checks every output transfer.
    always @(posedge i_clk) begin : monitor
        t_out_item res;
        t_out_item want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                step_estimator(i_data, res);
                if (pin_typed) begin
                    res = pin_exp;
                end
                pending_q.push_back(res);
                items_taken++;
                if (i_data.mode == MODE_CLEAR) begin
                    clears_taken++;
                end
                if (i_data.mode == MODE_SEED) begin
                    seeds_taken++;
                end
            end
            if (o_valid && i_ready) begin
                results_seen++;
                if (o_data.median_updated) begin
                    updates_seen++;
                end
                if (pending_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with nothing pending, got seconds %0d updated %0b",
                             $time, o_data.remaining_seconds, o_data.median_updated);
                end else begin
                    want = pending_q.pop_front();
                    if (o_data.remaining_seconds !== want.remaining_seconds) begin
                        fail_count++;
                        $display("%0t: remaining_seconds mismatch, expected %0d, got %0d",
                                 $time, want.remaining_seconds, o_data.remaining_seconds);
                    end
                    if (o_data.median_updated !== want.median_updated) begin
                        fail_count++;
                        $display("%0t: median_updated mismatch, expected %0b, got %0b",
                                 $time, want.median_updated, o_data.median_updated);
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
        end
    end

    // Ends a run in which no transfer happens for too long.
    initial begin
        stalled_cycles = 0;
        while (stalled_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, pending_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_row      rows[$];
        t_out_item none;
        none = '0;
        calm = 1'b0;
        gap_pct = 20;
        fail_count = 0;
        items_taken = 0;
        results_seen = 0;
        updates_seen = 0;
        clears_taken = 0;
        seeds_taken = 0;
        prev_speed = '0;
        prev_bytes = '0;
        wipe_estimator();
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_data    <= '0;
        pin_typed <= 1'b0;
        pin_exp   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: reset state, unused mode, clear, stalled ring pass,
        // seeds at the extremes, a seed with zero speed, and extreme samples.
        rows.push_back(mk_row(MODE_UNUSED, SPEED_MAX, BYTES_MAX, 1'b1, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, 40'd1, BYTES_MAX, 1'b0, '0, 1'b0));
        rows.push_back(mk_row(MODE_CLEAR, SPEED_MAX, BYTES_MAX, 1'b1, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, '0, BYTES_MAX, 1'b1, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, '0, '0, 1'b1, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, '0, 48'd1, 1'b1, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, '0, BYTES_MAX, 1'b1, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, '0, 48'd77, 1'b1, EST_INFINITE, 1'b1));
        rows.push_back(mk_row(MODE_SEED, 40'd1, BYTES_MAX, 1'b1, EST_W'(BYTES_MAX), 1'b1));
        rows.push_back(mk_row(MODE_SEED, '0, BYTES_MAX, 1'b1, '0, 1'b0));
        rows.push_back(mk_row(MODE_SEED, SPEED_MAX, '0, 1'b1, '0, 1'b1));
        rows.push_back(mk_row(MODE_SAMPLE, SPEED_MAX, BYTES_MAX, 1'b0, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, 40'd1, '0, 1'b0, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, 40'd3, 48'd10, 1'b0, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, 40'd7, 48'd7, 1'b0, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, '0, '0, 1'b0, '0, 1'b0));
        rows.push_back(mk_row(MODE_UNUSED, '0, '0, 1'b0, '0, 1'b0));
        rows.push_back(mk_row(MODE_SEED, 40'd2, 48'd5, 1'b0, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, 40'hAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b0, '0,
                              1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, 40'h55_5555_5555, 48'hAAAA_AAAA_AAAA, 1'b0, '0,
                              1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, SPEED_MAX, 48'd1, 1'b0, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, 40'd1, 48'h8000_0000_0000, 1'b0, '0, 1'b0));
        rows.push_back(mk_row(MODE_SAMPLE, 40'h80_0000_0000, BYTES_MAX, 1'b0, '0, 1'b0));
        foreach (rows[k]) begin
            send_item(rows[k].item, rows[k].typed, rows[k].want);
        end

        // Random part; idling changes character every so often and stops near the end.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 45;
                endcase
            end
            calm = (n >= RANDOM_ITEMS - CALM_TAIL);
            send_item(random_item(), 1'b0, none);
        end
        i_valid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d transfers in (%0d clears, %0d seeds) and %0d results out,",
                 items_taken, clears_taken, seeds_taken, results_seen);
        $display("with %0d median refreshes and %0d mismatches.", updates_seen, fail_count);
        if (fail_count == 0 && pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rtme_pkg.sv
hw/rtl/rtme_div.sv
hw/rtl/rtme_sort_cell.sv
hw/rtl/remaining_time_median_estimator.sv
bench/tb.sv
